[design/plcm_pkg.sv]
// Shared types and constants for the piecewise linear color map.
package plcm_pkg;
  localparam int CountW = 5;
  localparam int ValueW = 32;
  localparam int ChanW  = 8;
  localparam int ColorW = 24;
  localparam int DivW   = 34;
  localparam logic REQ_MAP   = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } color_t;

  typedef struct packed {
    logic               valid;
    logic               found;
    logic               low;
    logic signed [ValueW-1:0] value;
    logic signed [ValueW-1:0] prev_bp;
    color_t             prev_color;
    logic signed [ValueW-1:0] hit_bp;
    color_t             hit_color;
  } search_t;
endpackage

[design/piecewise_linear_color_map_core.sv]
// Top level of the piecewise linear color map.
// Input channel in_*: tdata carries entry_index, sample_value and the entry color,
// tuser carries req_type (1 = palette write, 0 = map a sample).
// Palette writes give no output and load one cell of the chain.
// A map transaction enters a chain of TABLE_ENTRIES cells, one per palette entry;
// the search token moves one cell a cycle.
// The three channels are then blended by a shared bit-serial divider, which is
// skipped when the sample is clamped to an end color.
// One map transaction is in flight at a time; in_tready is low for every
// transaction while it runs, so palette writes wait for the blend to finish.
// The result waits in an output register; while out_tready is low the block
// holds it and takes no new map transaction, palette writes are still taken.
// Reset clears the control state and sets entries_in_use to 2; palette
// contents are undefined until written.
// cfg_wr_en / cfg_wr_data write entries_in_use, clamped to 2..TABLE_ENTRIES.
module piecewise_linear_color_map_core #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  // entry_index[3:0], sample_value[35:4], red[43:36], green[51:44], blue[59:52]
  input  logic [63:0] in_tdata,
  input  logic        in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // pixel_red[7:0], pixel_green[15:8], pixel_blue[23:16]
);
  import plcm_pkg::*;
  localparam int IdxW = $clog2(TABLE_ENTRIES);

  logic [CountW-1:0] count_r;
  logic busy_r, busy_nxt, out_v_r;
  color_t out_r;
  search_t chain [TABLE_ENTRIES+1];
  search_t head;
  logic [8:0] last_idx;
  logic bl_done;
  color_t bl_res;

  logic acc, acc_wr, acc_map;
  assign acc = in_tvalid && in_tready;
  assign acc_wr = acc && in_tuser == REQ_WRITE;
  assign acc_map = acc && in_tuser == REQ_MAP;
  assign in_tready = !busy_r && (in_tuser == REQ_WRITE || !out_v_r);

  always_comb begin
    if (count_r < CountW'(2)) last_idx = 9'd1;
    else if (32'(count_r) > TABLE_ENTRIES) last_idx = 9'(TABLE_ENTRIES - 1);
    else last_idx = 9'(count_r) - 9'd1;
  end

  always_comb begin
    head = '0;
    head.valid = acc_map;
    head.value = in_tdata[35:4];
  end
  assign chain[0] = head;

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    plcm_cell #(.IDX(g), .IDX_W(IdxW)) u_cell (
      .clk, .rst_n,
      .wr_en(acc_wr && 32'(in_tdata[3:0]) < TABLE_ENTRIES),
      .wr_idx(IdxW'(in_tdata[3:0])),
      .wr_bp(in_tdata[35:4]),
      .wr_color({in_tdata[43:36], in_tdata[51:44], in_tdata[59:52]}),
      .is_last(last_idx == 9'(g)),
      .tok_in(chain[g]),
      .tok_out(chain[g+1])
    );
  end

  plcm_blend u_blend (
    .clk, .rst_n,
    .start(chain[TABLE_ENTRIES].valid),
    .tok(chain[TABLE_ENTRIES]),
    .done(bl_done), .result(bl_res)
  );

  always_comb begin
    busy_nxt = busy_r;
    if (acc_map) busy_nxt = 1'b1;
    else if (bl_done) busy_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= CountW'(2);
      busy_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (cfg_wr_en) count_r <= cfg_wr_data;
      busy_r <= busy_nxt;
      if (bl_done) out_v_r <= 1'b1;
      else if (out_tready) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (bl_done) out_r <= bl_res;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata = {out_r.blue, out_r.green, out_r.red};
endmodule

[design/plcm_cell.sv]
// One palette cell: holds a breakpoint and color, passes the search token on.
module plcm_cell #(
  parameter int IDX = 0,
  parameter int IDX_W = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [IDX_W-1:0]      wr_idx,
  input  logic signed [31:0]    wr_bp,
  input  plcm_pkg::color_t      wr_color,
  input  logic                  is_last,
  input  plcm_pkg::search_t     tok_in,
  output plcm_pkg::search_t     tok_out
);
  import plcm_pkg::*;
  logic signed [ValueW-1:0] bp_r;
  color_t color_r;
  search_t tok_nxt, tok_r;

  always_ff @(posedge clk) begin
    if (wr_en && wr_idx == IDX_W'(IDX)) begin
      bp_r    <= wr_bp;
      color_r <= wr_color;
    end
  end

  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.valid && !tok_in.found) begin
      if (IDX == 0) begin
        if (tok_in.value <= bp_r) begin
          tok_nxt.found = 1'b1;
          tok_nxt.low = 1'b1;
          tok_nxt.prev_bp = bp_r;
          tok_nxt.hit_bp = bp_r;
          tok_nxt.prev_color = color_r;
          tok_nxt.hit_color = color_r;
        end else begin
          tok_nxt.prev_bp = bp_r;
          tok_nxt.prev_color = color_r;
        end
      end else if (is_last && tok_in.value >= bp_r) begin
        tok_nxt.found = 1'b1;
        tok_nxt.prev_bp = bp_r;
        tok_nxt.hit_bp = bp_r;
        tok_nxt.prev_color = color_r;
        tok_nxt.hit_color = color_r;
      end else if (is_last || !(bp_r < tok_in.value)) begin
        tok_nxt.found = 1'b1;
        tok_nxt.hit_bp = bp_r;
        tok_nxt.hit_color = color_r;
      end else begin
        tok_nxt.prev_bp = bp_r;
        tok_nxt.prev_color = color_r;
      end
    end else if (tok_in.valid && is_last && !tok_in.low && tok_in.value >= bp_r) begin
      // at or above the last breakpoint wins over an earlier unsorted hit
      tok_nxt.prev_bp = bp_r;
      tok_nxt.hit_bp = bp_r;
      tok_nxt.prev_color = color_r;
      tok_nxt.hit_color = color_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r.valid <= tok_nxt.valid;
    end
    tok_r.found      <= tok_nxt.found;
    tok_r.low        <= tok_nxt.low;
    tok_r.value      <= tok_nxt.value;
    tok_r.prev_bp    <= tok_nxt.prev_bp;
    tok_r.prev_color <= tok_nxt.prev_color;
    tok_r.hit_bp     <= tok_nxt.hit_bp;
    tok_r.hit_color  <= tok_nxt.hit_color;
  end

  assign tok_out = tok_r;
endmodule

[design/plcm_blend.sv]
// Serial restoring divider that blends three channels between two colors.
module plcm_blend (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  plcm_pkg::search_t tok,
  output logic              done,
  output plcm_pkg::color_t  result
);
  import plcm_pkg::*;
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;
  localparam int TopW = 44;

  logic [1:0] state_r, state_nxt;
  logic [1:0] ch_r, ch_nxt;
  logic [5:0] bit_r, bit_nxt;
  logic [DivW-1:0] num_r, den_r;
  logic [ChanW-1:0] c0_r [3];
  logic [ChanW-1:0] c1_r [3];
  logic [TopW-1:0] top_r, quo_r;
  logic [TopW:0] rem_r;
  color_t res_r;
  logic flat_r;

  logic signed [9:0] diff;
  logic signed [TopW+1:0] prod;
  logic [TopW:0] rem_sh;
  logic [DivW:0] den2;

  always_comb begin
    diff = $signed({2'b00, c1_r[ch_r]}) - $signed({2'b00, c0_r[ch_r]});
    prod = $signed({12'd0, c0_r[ch_r]}) * $signed({12'd0, den_r})
         + diff * $signed({1'b0, num_r});
    den2 = {den_r, 1'b0};
    rem_sh = {rem_r[TopW-1:0], top_r[TopW-1]};
  end

  always_comb begin
    state_nxt = state_r;
    ch_nxt = ch_r;
    bit_nxt = bit_r;
    case (state_r)
      S_IDLE: if (start) begin
        state_nxt = S_MUL;
        ch_nxt = 2'd0;
      end
      S_MUL: begin
        state_nxt = flat_r ? S_DONE : S_DIV;
        bit_nxt = 6'(TopW - 1);
      end
      S_DIV: if (bit_r == 6'd0) begin
        if (ch_r == 2'd2) state_nxt = S_DONE;
        else begin
          state_nxt = S_MUL;
          ch_nxt = ch_r + 2'd1;
        end
      end else bit_nxt = bit_r - 6'd1;
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ch_r <= 2'd0;
      bit_r <= 6'd0;
    end else begin
      state_r <= state_nxt;
      ch_r <= ch_nxt;
      bit_r <= bit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: if (start) begin
        flat_r <= tok.hit_bp == tok.prev_bp;
        num_r <= DivW'($signed({tok.value[31], tok.value})
               - $signed({tok.prev_bp[31], tok.prev_bp}));
        den_r <= DivW'($signed({tok.hit_bp[31], tok.hit_bp})
               - $signed({tok.prev_bp[31], tok.prev_bp}));
        c0_r[0] <= tok.prev_color.red;
        c0_r[1] <= tok.prev_color.green;
        c0_r[2] <= tok.prev_color.blue;
        c1_r[0] <= tok.hit_color.red;
        c1_r[1] <= tok.hit_color.green;
        c1_r[2] <= tok.hit_color.blue;
        res_r <= tok.hit_color;
      end
      S_MUL: begin
        top_r <= TopW'({prod[TopW-1:0], 1'b0} + TopW'(den_r));
        rem_r <= '0;
        quo_r <= '0;
      end
      S_DIV: begin
        top_r <= {top_r[TopW-2:0], 1'b0};
        if (rem_sh >= (TopW+1)'(den2)) begin
          rem_r <= rem_sh - (TopW+1)'(den2);
          quo_r <= {quo_r[TopW-2:0], 1'b1};
          if (bit_r == 6'd0) begin
            case (ch_r)
              2'd0: res_r.red <= ChanW'({quo_r[TopW-2:0], 1'b1});
              2'd1: res_r.green <= ChanW'({quo_r[TopW-2:0], 1'b1});
              default: res_r.blue <= ChanW'({quo_r[TopW-2:0], 1'b1});
            endcase
          end
        end else begin
          rem_r <= rem_sh;
          quo_r <= {quo_r[TopW-2:0], 1'b0};
          if (bit_r == 6'd0) begin
            case (ch_r)
              2'd0: res_r.red <= ChanW'({quo_r[TopW-2:0], 1'b0});
              2'd1: res_r.green <= ChanW'({quo_r[TopW-2:0], 1'b0});
              default: res_r.blue <= ChanW'({quo_r[TopW-2:0], 1'b0});
            endcase
          end
        end
      end
      default: ;
    endcase
  end

  assign done = state_r == S_DONE;
  assign result = res_r;
endmodule

[design/plcm_checker.sv]
// Port-level assertions for the color map core.
module plcm_checker (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic in_tuser,
  input logic out_tvalid,
  input logic out_tready,
  input logic [23:0] out_tdata
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed while stalled");
  a_wr_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && in_tvalid && in_tuser |-> in_tready)
    else $error("palette write refused while result pending");
  a_no_map_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !in_tuser |-> !in_tready)
    else $error("map taken while result pending");
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");
endmodule

bind piecewise_linear_color_map_core plcm_checker u_plcm_checker (
  .clk, .rst_n, .in_tvalid, .in_tready, .in_tuser,
  .out_tvalid, .out_tready, .out_tdata
);
